@@ hdl/lar_pkg.sv @@
// ---------------------------------------------------------------------------
// lar_pkg
// Shared types and codes for the LED animation record parser.
// ---------------------------------------------------------------------------
`default_nettype none

package lar_pkg;

   // result kind codes
   localparam logic [1:0] KIND_TITLE     = 2'd0;
   localparam logic [1:0] KIND_PIXEL     = 2'd1;
   localparam logic [1:0] KIND_EMPTY     = 2'd2;
   localparam logic [1:0] KIND_NO_FRAMES = 2'd3;

   // coordinate byte nibble masks
   localparam logic [7:0] X_MASK = 8'hf0;
   localparam logic [7:0] Y_MASK = 8'h0f;

   // one decoded result
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] title_char;
      logic [7:0] frame_index;
      logic [3:0] pixel_x;
      logic [3:0] pixel_y;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_done;
      logic       animation_done;
   } lar_result_type;

endpackage

`default_nettype wire

@@ hdl/led_animation_record_parser.sv @@
// ---------------------------------------------------------------------------
// led_animation_record_parser
// Byte-stream parser for LED animation records: emits title characters,
// decoded pixels and frame / animation end marks.
// ---------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  req_      in         req_valid/req_stall data_byte, record_start
//  rsp_      out        rsp_valid/rsp_stall kind .. animation_done
//
//  One byte per cycle sustained while no result is held under rsp_stall;
//  a byte sits in the input register, is decoded and its result lands in
//  the output register, from which the result is valid.
//  A held result under rsp_stall blocks decoding; req_stall rises only
//  when the input register is full and cannot move on.
//  Reset (synchronous) empties both registers and idles the parser.
// ---------------------------------------------------------------------------
`default_nettype none

module led_animation_record_parser (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire  [7:0] req_data_byte,
   input  wire        req_record_start,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_title_char,
   output logic [7:0] rsp_frame_index,
   output logic [3:0] rsp_pixel_x,
   output logic [3:0] rsp_pixel_y,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue,
   output logic       rsp_frame_done,
   output logic       rsp_animation_done
);
   import lar_pkg::*;

   logic           in_valid_ff;
   logic [7:0]     in_byte_ff;
   logic           in_start_ff;
   logic           out_valid_ff;
   lar_result_type out_ff;
   lar_result_type res;
   logic           res_valid;
   logic           out_free;
   logic           step;
   logic           req_take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   lar_decoder u_decoder (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .data_byte    (in_byte_ff),
      .record_start (in_start_ff),
      .res_valid    (res_valid),
      .res          (res)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (step) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_data_byte;
         in_start_ff <= req_record_start;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= step && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = out_ff.kind;
   assign rsp_title_char     = out_ff.title_char;
   assign rsp_frame_index    = out_ff.frame_index;
   assign rsp_pixel_x        = out_ff.pixel_x;
   assign rsp_pixel_y        = out_ff.pixel_y;
   assign rsp_red            = out_ff.red;
   assign rsp_green          = out_ff.green;
   assign rsp_blue           = out_ff.blue;
   assign rsp_frame_done     = out_ff.frame_done;
   assign rsp_animation_done = out_ff.animation_done;

endmodule

`default_nettype wire

@@ hdl/lar_decoder.sv @@
// ---------------------------------------------------------------------------
// lar_decoder
// Record state machine: consumes one byte per step and forms the result
// that the byte causes, if any.
// ---------------------------------------------------------------------------
`default_nettype none

module lar_decoder (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     step,
   input  wire [7:0]               data_byte,
   input  wire                     record_start,
   output logic                    res_valid,
   output lar_pkg::lar_result_type res
);
   import lar_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_TITLE,
      PH_FRAMES,
      PH_COUNT_HI,
      PH_COUNT_LO,
      PH_COORD,
      PH_RED,
      PH_GREEN,
      PH_BLUE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  title_left_ff, title_left_in;
   logic [7:0]  frames_left_ff, frames_left_in;
   logic [7:0]  current_frame_ff, current_frame_in;
   logic [15:0] pixels_left_ff, pixels_left_in;
   logic [7:0]  count_high_ff, count_high_in;
   logic [7:0]  coords_ff, coords_in;
   logic [7:0]  red_ff, red_in;
   logic [7:0]  green_ff, green_in;

   logic [7:0]  title_dec;
   logic [7:0]  frames_dec;
   logic [7:0]  frame_inc;
   logic [15:0] pixels_dec;
   logic [15:0] pixel_count;

   assign title_dec   = title_left_ff - 8'd1;
   assign frames_dec  = frames_left_ff - 8'd1;
   assign frame_inc   = current_frame_ff + 8'd1;
   assign pixels_dec  = pixels_left_ff - 16'd1;
   assign pixel_count = {count_high_ff, data_byte};

   // next state and result for the byte at hand
   always_comb begin
      phase_in         = phase_ff;
      title_left_in    = title_left_ff;
      frames_left_in   = frames_left_ff;
      current_frame_in = current_frame_ff;
      pixels_left_in   = pixels_left_ff;
      count_high_in    = count_high_ff;
      coords_in        = coords_ff;
      red_in           = red_ff;
      green_in         = green_ff;
      res_valid        = 1'b0;
      res              = '0;

      if (record_start) begin
         // restart: byte is the title length
         title_left_in    = data_byte;
         frames_left_in   = '0;
         current_frame_in = '0;
         pixels_left_in   = '0;
         phase_in         = (data_byte == 8'd0) ? PH_FRAMES : PH_TITLE;
      end else begin
         case (phase_ff)
            PH_TITLE: begin
               res_valid      = 1'b1;
               res.kind       = KIND_TITLE;
               res.title_char = data_byte;
               title_left_in  = title_dec;
               if (title_dec == 8'd0) begin
                  phase_in = PH_FRAMES;
               end
            end
            PH_FRAMES: begin
               frames_left_in   = data_byte;
               current_frame_in = '0;
               if (data_byte == 8'd0) begin
                  res_valid          = 1'b1;
                  res.kind           = KIND_NO_FRAMES;
                  res.animation_done = 1'b1;
                  phase_in           = PH_IDLE;
               end else begin
                  phase_in = PH_COUNT_HI;
               end
            end
            PH_COUNT_HI: begin
               count_high_in = data_byte;
               phase_in      = PH_COUNT_LO;
            end
            PH_COUNT_LO: begin
               pixels_left_in = pixel_count;
               if (pixel_count == 16'd0) begin
                  // empty frame closes at once
                  res_valid          = 1'b1;
                  res.kind           = KIND_EMPTY;
                  res.frame_index    = current_frame_ff;
                  res.frame_done     = 1'b1;
                  res.animation_done = (frames_dec == 8'd0);
                  frames_left_in     = frames_dec;
                  current_frame_in   = frame_inc;
                  phase_in           = (frames_dec == 8'd0) ? PH_IDLE : PH_COUNT_HI;
               end else begin
                  phase_in = PH_COORD;
               end
            end
            PH_COORD: begin
               coords_in = data_byte;
               phase_in  = PH_RED;
            end
            PH_RED: begin
               red_in   = data_byte;
               phase_in = PH_GREEN;
            end
            PH_GREEN: begin
               green_in = data_byte;
               phase_in = PH_BLUE;
            end
            PH_BLUE: begin
               res_valid       = 1'b1;
               res.kind        = KIND_PIXEL;
               res.frame_index = current_frame_ff;
               res.pixel_x     = 4'((coords_ff & X_MASK) >> 4);
               res.pixel_y     = 4'(coords_ff & Y_MASK);
               res.red         = red_ff;
               res.green       = green_ff;
               res.blue        = data_byte;
               pixels_left_in  = pixels_dec;
               if (pixels_dec == 16'd0) begin
                  // last pixel of the frame
                  res.frame_done     = 1'b1;
                  res.animation_done = (frames_dec == 8'd0);
                  frames_left_in     = frames_dec;
                  current_frame_in   = frame_inc;
                  phase_in           = (frames_dec == 8'd0) ? PH_IDLE : PH_COUNT_HI;
               end else begin
                  phase_in = PH_COORD;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         title_left_ff    <= '0;
         frames_left_ff   <= '0;
         current_frame_ff <= '0;
         pixels_left_ff   <= '0;
         count_high_ff    <= '0;
      end else if (step) begin
         phase_ff         <= phase_in;
         title_left_ff    <= title_left_in;
         frames_left_ff   <= frames_left_in;
         current_frame_ff <= current_frame_in;
         pixels_left_ff   <= pixels_left_in;
         count_high_ff    <= count_high_in;
      end
   end

   // held pixel bytes
   always_ff @(posedge clock) begin
      if (step) begin
         coords_ff <= coords_in;
         red_ff    <= red_in;
         green_ff  <= green_in;
      end
   end

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// Testbench for the LED animation record parser. It streams records byte by
// byte, predicts every title character, pixel and end mark in step with the
// parser, and checks each result in order. Both sides idle at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

   import lar_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;   // cycles with no handshake at all
   localparam int HOLD_CYCLES    = 200;    // long output hold-off
   localparam int DRAIN_CYCLES   = 8;      // settle time after the last expected result
   localparam int RANDOM_BYTES   = 1000;

   // parser phases, tracked by the predictor
   typedef enum logic [3:0] {
      PH_IDLE, PH_TITLE, PH_FRAMES, PH_COUNT_HI, PH_COUNT_LO,
      PH_COORD, PH_RED, PH_GREEN, PH_BLUE
   } parse_phase_type;

   // one byte of a record waiting to be sent
   typedef struct packed {
      logic       start;
      logic [7:0] data;
   } record_byte_type;

   logic       clock;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte    = 8'h00;
   logic       req_record_start = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_title_char;
   logic [7:0] rsp_frame_index;
   logic [3:0] rsp_pixel_x;
   logic [3:0] rsp_pixel_y;
   logic [7:0] rsp_red;
   logic [7:0] rsp_green;
   logic [7:0] rsp_blue;
   logic       rsp_frame_done;
   logic       rsp_animation_done;

   // predictor state
   parse_phase_type parse_phase   = PH_IDLE;
   logic [7:0]   title_remaining  = 8'h00;
   logic [7:0]   frames_remaining = 8'h00;
   logic [7:0]   frame_num        = 8'h00;
   logic [15:0]  pixels_remaining = 16'h0000;
   logic [7:0]   count_hi         = 8'h00;
   logic [7:0]   coord_byte       = 8'h00;
   logic [7:0]   red_byte         = 8'h00;
   logic [7:0]   green_byte       = 8'h00;

   lar_result_type  expected_results[$];
   record_byte_type pending_bytes[$];

   int  error_count   = 0;
   int  requests_sent = 0;
   int  kind_count[4] = '{0, 0, 0, 0};
   bit  idle_en       = 1'b0;
   bit  hold_request  = 1'b0;
   int  hold_left     = 0;
   int  quiet_cycles  = 0;

   led_animation_record_parser u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_record_start   (req_record_start),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_title_char     (rsp_title_char),
      .rsp_frame_index    (rsp_frame_index),
      .rsp_pixel_x        (rsp_pixel_x),
      .rsp_pixel_y        (rsp_pixel_y),
      .rsp_red            (rsp_red),
      .rsp_green          (rsp_green),
      .rsp_blue           (rsp_blue),
      .rsp_frame_done     (rsp_frame_done),
      .rsp_animation_done (rsp_animation_done)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // --- predictor ---------------------------------------------------------

   // close the current frame; 1 when it was the last one
   function automatic bit close_frame();
      frames_remaining = frames_remaining - 8'd1;
      frame_num        = frame_num + 8'd1;
      if (frames_remaining == 8'd0) begin
         parse_phase = PH_IDLE;
         return 1'b1;
      end
      parse_phase = PH_COUNT_HI;
      return 1'b0;
   endfunction

   // advance the parser by one accepted byte, queue any result it yields
   function automatic void decode_byte(input logic [7:0] b, input logic start);
      lar_result_type r;
      bit             produced;
      r        = '0;
      produced = 1'b0;
      if (start) begin
         title_remaining  = b;
         frames_remaining = 8'd0;
         frame_num        = 8'd0;
         pixels_remaining = 16'd0;
         parse_phase      = (b == 8'd0) ? PH_FRAMES : PH_TITLE;
      end else begin
         case (parse_phase)
            PH_TITLE: begin
               r.kind          = KIND_TITLE;
               r.title_char    = b;
               produced        = 1'b1;
               title_remaining = title_remaining - 8'd1;
               if (title_remaining == 8'd0) parse_phase = PH_FRAMES;
            end
            PH_FRAMES: begin
               frames_remaining = b;
               frame_num        = 8'd0;
               if (b == 8'd0) begin
                  r.kind           = KIND_NO_FRAMES;
                  r.animation_done = 1'b1;
                  produced         = 1'b1;
                  parse_phase      = PH_IDLE;
               end else begin
                  parse_phase = PH_COUNT_HI;
               end
            end
            PH_COUNT_HI: begin
               count_hi    = b;
               parse_phase = PH_COUNT_LO;
            end
            PH_COUNT_LO: begin
               pixels_remaining = {count_hi, b};
               if (pixels_remaining == 16'd0) begin
                  r.kind           = KIND_EMPTY;
                  r.frame_index    = frame_num;
                  r.frame_done     = 1'b1;
                  r.animation_done = close_frame();
                  produced         = 1'b1;
               end else begin
                  parse_phase = PH_COORD;
               end
            end
            PH_COORD: begin
               coord_byte  = b;
               parse_phase = PH_RED;
            end
            PH_RED: begin
               red_byte    = b;
               parse_phase = PH_GREEN;
            end
            PH_GREEN: begin
               green_byte  = b;
               parse_phase = PH_BLUE;
            end
            PH_BLUE: begin
               r.kind        = KIND_PIXEL;
               r.frame_index = frame_num;
               r.pixel_x     = 4'((coord_byte & X_MASK) >> 4);
               r.pixel_y     = 4'(coord_byte & Y_MASK);
               r.red         = red_byte;
               r.green       = green_byte;
               r.blue        = b;
               produced      = 1'b1;
               pixels_remaining = pixels_remaining - 16'd1;
               if (pixels_remaining == 16'd0) begin
                  r.frame_done     = 1'b1;
                  r.animation_done = close_frame();
               end else begin
                  parse_phase = PH_COORD;
               end
            end
            default: parse_phase = PH_IDLE;   // idle bytes are dropped
         endcase
      end
      if (produced) expected_results.push_back(r);
   endfunction

   // --- checker -----------------------------------------------------------

   function automatic void check_field(input string name_s, input int unsigned exp_v,
                                       input int unsigned act_v);
      if (exp_v != act_v) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name_s, exp_v, act_v);
      end
   endfunction

   // predict on each accepted request, compare each accepted result
   always @(posedge clock) begin
      lar_result_type exp_r;
      if (!reset) begin
         if (req_valid && !req_stall) decode_byte(req_data_byte, req_record_start);
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none, actual kind %0d",
                        $time, rsp_kind);
            end else begin
               exp_r = expected_results.pop_front();
               check_field("kind",           exp_r.kind,           rsp_kind);
               check_field("title_char",     exp_r.title_char,     rsp_title_char);
               check_field("frame_index",    exp_r.frame_index,    rsp_frame_index);
               check_field("pixel_x",        exp_r.pixel_x,        rsp_pixel_x);
               check_field("pixel_y",        exp_r.pixel_y,        rsp_pixel_y);
               check_field("red",            exp_r.red,            rsp_red);
               check_field("green",          exp_r.green,          rsp_green);
               check_field("blue",           exp_r.blue,           rsp_blue);
               check_field("frame_done",     exp_r.frame_done,     rsp_frame_done);
               check_field("animation_done", exp_r.animation_done, rsp_animation_done);
            end
            kind_count[rsp_kind]++;
         end
      end
   end

   // --- receiver: random stall, plus a long hold-off on request -----------
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (idle_en) begin
            rsp_stall <= ($urandom_range(0, 99) < 34);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // --- watchdog: cycles without any handshake ----------------------------
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               expected_results.size());
      $display("CHECK FAILED");
      $finish;
   end

   // --- sender ------------------------------------------------------------

   // offer one request, optionally after a gap, and wait until it is taken
   task automatic send_request(input logic start, input logic [7:0] b);
      int gap;
      if (idle_en && $urandom_range(0, 99) < 34) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_record_start <= start;
      req_data_byte    <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
   endtask

   function automatic void add_byte(input logic start, input logic [7:0] b);
      record_byte_type item;
      item.start = start;
      item.data  = b;
      pending_bytes.push_back(item);
   endfunction

   task automatic flush_bytes();
      record_byte_type item;
      while (pending_bytes.size() > 0) begin
         item = pending_bytes.pop_front();
         send_request(item.start, item.data);
      end
   endtask

   // well-formed record with random content, up to max_pixels per frame
   function automatic void build_record(input int title_len, input int frame_cnt,
                                        input int max_pixels);
      int px;
      add_byte(1'b1, 8'(title_len));
      repeat (title_len) add_byte(1'b0, 8'($urandom_range(0, 255)));
      add_byte(1'b0, 8'(frame_cnt));
      repeat (frame_cnt) begin
         px = $urandom_range(0, max_pixels);
         add_byte(1'b0, 8'(px >> 8));
         add_byte(1'b0, 8'(px));
         repeat (px * 4) add_byte(1'b0, 8'($urandom_range(0, 255)));
      end
   endfunction

   // --- tests -------------------------------------------------------------

   // bytes before any record are dropped
   task automatic test_idle_bytes();
      add_byte(1'b0, 8'hff);
      add_byte(1'b0, 8'h00);
      flush_bytes();
   endtask

   // two title chars, a two-pixel frame at the extremes, then an empty frame
   task automatic test_full_record();
      add_byte(1'b1, 8'h02);
      add_byte(1'b0, 8'h00);
      add_byte(1'b0, 8'hff);
      add_byte(1'b0, 8'h02);
      add_byte(1'b0, 8'h00);
      add_byte(1'b0, 8'h02);
      add_byte(1'b0, 8'hff);
      add_byte(1'b0, 8'hff);
      add_byte(1'b0, 8'h00);
      add_byte(1'b0, 8'hff);
      add_byte(1'b0, 8'h00);
      add_byte(1'b0, 8'h00);
      add_byte(1'b0, 8'hff);
      add_byte(1'b0, 8'h00);
      add_byte(1'b0, 8'h00);
      add_byte(1'b0, 8'h00);
      add_byte(1'b0, 8'ha5);   // after the end: dropped
      flush_bytes();
   endtask

   // empty title straight into a zero frame count
   task automatic test_no_frames();
      add_byte(1'b1, 8'h00);
      add_byte(1'b0, 8'h00);
      flush_bytes();
   endtask

   // a long title abandoned by a new record start
   task automatic test_restart_mid_record();
      add_byte(1'b1, 8'hff);
      add_byte(1'b0, 8'h41);
      add_byte(1'b1, 8'h00);
      add_byte(1'b0, 8'h01);
      add_byte(1'b0, 8'h00);
      add_byte(1'b0, 8'h00);
      flush_bytes();
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_output_hold_off();
      idle_en      = 1'b0;
      hold_request = 1'b1;
      build_record(12, 2, 3);
      flush_bytes();
      idle_en = 1'b1;
   endtask

   // pixel count 0x0101: three pixels cross the low byte wrap without
   // closing the frame; the next record start abandons it
   task automatic test_long_frame();
      add_byte(1'b1, 8'h00);
      add_byte(1'b0, 8'h01);
      add_byte(1'b0, 8'h01);
      add_byte(1'b0, 8'h01);
      repeat (3 * 4) add_byte(1'b0, 8'($urandom_range(0, 255)));
      flush_bytes();
   endtask

   // 255 empty frames: frame index runs up to 254
   task automatic test_many_frames();
      build_record(1, 255, 0);
      flush_bytes();
   endtask

   // mostly well-formed records, some cut short, some junk
   task automatic test_random_records();
      int counted;
      int pick;
      int cut;
      int title_len;
      int frame_cnt;
      counted = 0;
      while (counted < RANDOM_BYTES) begin
         // one stretch with no idling on either side
         idle_en = !(counted >= 600 && counted < 900);
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            title_len = ($urandom_range(0, 59) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 4);
            frame_cnt = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
            build_record(title_len, frame_cnt, 3);
            counted += pending_bytes.size();
            if ($urandom_range(0, 9) < 3)
               repeat ($urandom_range(1, 3)) add_byte(1'b0, 8'($urandom_range(0, 255)));
         end else if (pick < 92) begin
            if ($urandom_range(0, 1) == 0) begin
               build_record($urandom_range(0, 4), $urandom_range(1, 3), 3);
            end else begin
               // header with an arbitrary 16-bit pixel count
               add_byte(1'b1, 8'h00);
               add_byte(1'b0, 8'($urandom_range(1, 255)));
               add_byte(1'b0, 8'($urandom_range(0, 255)));
               add_byte(1'b0, 8'($urandom_range(0, 255)));
               repeat ($urandom_range(0, 12)) add_byte(1'b0, 8'($urandom_range(0, 255)));
            end
            cut = $urandom_range(1, pending_bytes.size() - 1);
            while (pending_bytes.size() > cut) void'(pending_bytes.pop_back());
            counted += pending_bytes.size();
         end else begin
            repeat ($urandom_range(1, 6))
               add_byte($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
         end
         flush_bytes();
      end
      idle_en = 1'b1;
   endtask

   // --- sequence ----------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      reset   <= 1'b0;
      idle_en = 1'b1;

      test_idle_bytes();
      test_full_record();
      test_no_frames();
      test_restart_mid_record();
      test_output_hold_off();
      test_long_frame();
      test_many_frames();
      test_random_records();
      req_valid <= 1'b0;

      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_results.size() != 0) begin
         error_count++;
         $display("%0t: %0d results never arrived", $time, expected_results.size());
      end

      $display("Sent %0d requests; got %0d title, %0d pixel, %0d empty-frame, %0d no-frame.",
               requests_sent, kind_count[KIND_TITLE], kind_count[KIND_PIXEL],
               kind_count[KIND_EMPTY], kind_count[KIND_NO_FRAMES]);
      $display("Covered restarts, cut records, junk, 255 frames, a 257-pixel count, %0d-cycle hold.",
               HOLD_CYCLES);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ led_animation_record_parser.f @@
hdl/lar_pkg.sv
hdl/lar_decoder.sv
hdl/led_animation_record_parser.sv
verif/tb_top.sv
